@@ sv/bus_pkg.sv @@
// Package for the bounded undo stack: field widths, operation codes, error codes
// and the default sizes. It depends on nothing else.
package bus_pkg;

  localparam int FUNC_W     = 2;
  localparam int ITEM_W     = 32;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int ERROR_W    = 2;
  localparam int CAP_W      = 7;

  localparam int DEPTH_DEF  = 64;
  localparam int ITEM_W_DEF = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  localparam logic [ERROR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERROR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERROR_W-1:0] ERR_RANGE = 2'd2;

endpackage

@@ sv/bus_in_if.sv @@
// Operation channel of the undo stack: valid/ready plus one operation word.
// Depends on bus_pkg for the field widths.
interface bus_in_if;
  logic                        valid;
  logic                        ready;
  logic [bus_pkg::FUNC_W-1:0]  func;
  logic [bus_pkg::ITEM_W-1:0]  item;
  logic [bus_pkg::INDEX_W-1:0] index;

  modport source (output valid, func, item, index, input ready);
  modport sink   (input valid, func, item, index, output ready);
endinterface

@@ sv/bus_out_if.sv @@
// Result channel of the undo stack: valid/ready plus one result word.
// Depends on bus_pkg for the field widths.
interface bus_out_if;
  logic                        valid;
  logic                        ready;
  logic [bus_pkg::ITEM_W-1:0]  item_out;
  logic                        evicted;
  logic [bus_pkg::ERROR_W-1:0] error;
  logic [bus_pkg::COUNT_W-1:0] count;
  logic                        full_res;
  logic                        empty_res;

  modport source (output valid, item_out, evicted, error, count, full_res, empty_res,
                  input ready);
  modport sink   (input valid, item_out, evicted, error, count, full_res, empty_res,
                  output ready);
endinterface

@@ sv/bus_cfg_if.sv @@
// Configuration write channel of the undo stack: valid/ready plus the capacity word.
// Depends on bus_pkg for the field width.
interface bus_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bus_pkg::CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

@@ sv/bus_ring_ram.sv @@
// Entry store of the undo stack: one write port, one read port with registered data.
// Read returns the old contents on a same-address write. No package dependency.
module bus_ring_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/bounded_undo_stack.sv @@
// Top level of the bounded undo stack: ring pointer, count, capacity register
// and result register. Uses bus_pkg, the bus_*_if interfaces and bus_ring_ram.
//
//   channel   dir  handshake        word
//   in_ch     in   valid/ready      func, item, index
//   out_ch    out  valid/ready      item_out, evicted, error, count, full_res, empty_res
//   cfg_ch    in   valid/ready      capacity
//
// One operation per cycle while in_ch.ready is high; the result appears in the cycle after acceptance.
// The result item comes from the registered read port of the entry store.
// in_ch.ready is high while the result register is empty or being drained.
// rst_n (synchronous) clears pointer, count and valid; capacity returns to 64.
// cfg_ch.ready is always high.
module bounded_undo_stack #(
  parameter int DEPTH      = bus_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = bus_pkg::ITEM_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bus_in_if.sink    in_ch,
  bus_out_if.source out_ch,
  bus_cfg_if.sink   cfg_ch
);
  import bus_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [CAP_W-1:0]      cap_r;
  logic [AW-1:0]         oldest_r, oldest_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r;
  logic                  use_rd_r, use_rd_nxt;
  logic                  evicted_r, evicted_nxt;
  logic [ERROR_W-1:0]    error_r, error_nxt;
  logic [COUNT_W-1:0]    count_out_r;
  logic                  full_r, empty_r;

  logic                  acc;
  logic [CW-1:0]         eff_cap;
  logic [CW+CAP_W-1:0]   cap_x;
  logic [CW+INDEX_W-1:0] idx_x;
  logic [CW+COUNT_W-1:0] cnt_x;
  logic                  full_now;
  logic [CW-1:0]         rd_pos;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;
  logic [ITEM_WIDTH+ITEM_W-1:0] wr_ext, rd_ext;
  logic [ITEM_WIDTH-1:0]  rd_data;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cap_x = {{CW{1'b0}}, cap_r};
  assign idx_x = {{CW{1'b0}}, in_ch.index};

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > (CW + CAP_W)'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_x[CW-1:0];
    end
  end

  assign full_now = count_r >= eff_cap;

  always_comb begin
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    use_rd_nxt  = 1'b0;
    evicted_nxt = 1'b0;
    error_nxt   = ERR_OK;
    rd_pos      = '0;
    wr_en       = 1'b0;
    unique case (func_t'(in_ch.func))
      FUNC_PUSH: begin
        wr_en = 1'b1;
        if (full_now) begin
          use_rd_nxt  = 1'b1;
          evicted_nxt = 1'b1;
          oldest_nxt  = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + AW'(1);
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      FUNC_POP: begin
        if (count_r == '0) begin
          error_nxt = ERR_EMPTY;
        end else begin
          count_nxt  = count_r - CW'(1);
          rd_pos     = count_r - CW'(1);
          use_rd_nxt = 1'b1;
        end
      end
      FUNC_PEEK: begin
        if (count_r == '0) begin
          error_nxt = ERR_EMPTY;
        end else begin
          rd_pos     = count_r - CW'(1);
          use_rd_nxt = 1'b1;
        end
      end
      FUNC_READ: begin
        if (idx_x >= (CW + INDEX_W)'(count_r)) begin
          error_nxt = ERR_RANGE;
        end else begin
          rd_pos     = idx_x[CW-1:0];
          use_rd_nxt = 1'b1;
        end
      end
      default: begin
        error_nxt = ERR_OK;
      end
    endcase
  end

  assign rd_addr = slot(oldest_r, rd_pos);
  assign wr_addr = slot(oldest_r, count_r);
  assign wr_ext  = {{ITEM_WIDTH{1'b0}}, in_ch.item};
  assign cnt_x   = {{COUNT_W{1'b0}}, count_nxt};

  bus_ring_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ITEM_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (acc && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ext[ITEM_WIDTH-1:0]),
    .rd_en   (acc && use_rd_nxt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.capacity;
      end
      if (acc) begin
        oldest_r    <= oldest_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      use_rd_r    <= use_rd_nxt;
      evicted_r   <= evicted_nxt;
      error_r     <= error_nxt;
      count_out_r <= cnt_x[COUNT_W-1:0];
      full_r      <= count_nxt >= eff_cap;
      empty_r     <= count_nxt == '0;
    end
  end

  assign rd_ext = {{ITEM_W{1'b0}}, rd_data};

  assign out_ch.valid     = out_valid_r;
  assign out_ch.item_out  = use_rd_r ? rd_ext[ITEM_W-1:0] : '0;
  assign out_ch.evicted   = evicted_r;
  assign out_ch.error     = error_r;
  assign out_ch.count     = count_out_r;
  assign out_ch.full_res  = full_r;
  assign out_ch.empty_res = empty_r;

endmodule

@@ tb/sv/tb_bounded_undo_stack.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bounded_undo_stack: directed and random stack operations
// with random idling on both channels, checked against a ring-based history model.
// Depends on bus_pkg, bus_in_if, bus_out_if, bus_cfg_if and the stack RTL.
module tb_bounded_undo_stack;
  import bus_pkg::*;

  localparam int HIST_DEPTH  = 64;
  localparam int MAX_GAP     = 8;
  localparam int HOLD_LEN    = 60;
  localparam int MAX_REPORTS = 40;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef struct packed {
    logic [ITEM_W-1:0]  word;
    logic               evicted;
    logic [ERROR_W-1:0] err;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } stack_result_t;

  logic clk;
  logic rst_n;

  bus_in_if  in_if();
  bus_out_if out_if();
  bus_cfg_if cfg_if();

  bounded_undo_stack u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // history model
  logic [ITEM_W-1:0]  hist_ring [HIST_DEPTH];
  logic [INDEX_W-1:0] hist_oldest;
  int unsigned        hist_count;
  logic [CAP_W-1:0]   hist_cap;

  stack_result_t pending_results[$];

  int  err_cnt;
  int  words_sent;
  int  words_checked;
  int  push_cnt;
  int  evict_cnt;
  int  err_result_cnt;
  bit  burst_mode;
  int  rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned eff_capacity();
    if (hist_cap == '0) return 1;
    if (hist_cap > HIST_DEPTH) return HIST_DEPTH;
    return hist_cap;
  endfunction

  function automatic logic [INDEX_W-1:0] ring_slot(int unsigned pos);
    return hist_oldest + INDEX_W'(pos);
  endfunction

  function automatic stack_result_t apply_stack_op(func_t f, logic [ITEM_W-1:0] w,
                                                   logic [INDEX_W-1:0] ix);
    stack_result_t r;
    int unsigned cap;
    r = '0;
    cap = eff_capacity();
    case (f)
      FUNC_PUSH: begin
        push_cnt++;
        if (hist_count >= cap) begin
          r.word = hist_ring[ring_slot(0)];
          r.evicted = 1'b1;
          evict_cnt++;
          hist_oldest = hist_oldest + 1'b1;
          hist_ring[ring_slot(hist_count - 1)] = w;
        end else begin
          hist_ring[ring_slot(hist_count)] = w;
          hist_count++;
        end
      end
      FUNC_POP: begin
        if (hist_count == 0) begin
          r.err = ERR_EMPTY;
        end else begin
          hist_count--;
          r.word = hist_ring[ring_slot(hist_count)];
        end
      end
      FUNC_PEEK: begin
        if (hist_count == 0) r.err = ERR_EMPTY;
        else r.word = hist_ring[ring_slot(hist_count - 1)];
      end
      default: begin
        if (ix >= hist_count) r.err = ERR_RANGE;
        else r.word = hist_ring[ring_slot(ix)];
      end
    endcase
    if (r.err != ERR_OK) err_result_cnt++;
    r.count = COUNT_W'(hist_count);
    r.full  = (hist_count >= cap);
    r.empty = (hist_count == 0);
    return r;
  endfunction

  // called at a rising edge; returns at the edge the word is taken, valid left high
  task automatic send_word(func_t f, logic [ITEM_W-1:0] w, logic [INDEX_W-1:0] ix);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.item  <= w;
    in_if.index <= ix;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pending_results.push_back(apply_stack_op(f, w, ix));
    words_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    hist_cap = cap;
  endtask

  function automatic void cmp_field(string name, logic [ITEM_W-1:0] exp_v,
                                    logic [ITEM_W-1:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  task automatic check_result();
    stack_result_t exp_r;
    words_checked++;
    if (pending_results.size() == 0) begin
      err_cnt++;
      $display("%0t: result word with none pending, expected none, actual %0h",
               $time, out_if.item_out);
    end else begin
      exp_r = pending_results.pop_front();
      cmp_field("item_out",  exp_r.word,    out_if.item_out);
      cmp_field("evicted",   exp_r.evicted, out_if.evicted);
      cmp_field("error",     exp_r.err,     out_if.error);
      cmp_field("count",     exp_r.count,   out_if.count);
      cmp_field("full_res",  exp_r.full,    out_if.full_res);
      cmp_field("empty_res", exp_r.empty,   out_if.empty_res);
    end
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      check_result();
    end
  end

  task automatic send_random_ops(int n, int push_pct);
    int r;
    int span;
    func_t f;
    logic [INDEX_W-1:0] ix;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      span = 100 - push_pct;
      if (r < push_pct) f = FUNC_PUSH;
      else if ((r - push_pct) * 100 < span * 35) f = FUNC_POP;
      else if ((r - push_pct) * 100 < span * 55) f = FUNC_PEEK;
      else f = FUNC_READ;
      if (hist_count > 0 && $urandom_range(0, 4) != 0)
        ix = INDEX_W'($urandom_range(0, hist_count - 1));
      else
        ix = INDEX_W'($urandom_range(0, HIST_DEPTH - 1));
      send_word(f, $urandom, ix);
    end
  endtask

  task automatic test_empty_and_edges();
    send_word(FUNC_POP,  '0, '0);
    send_word(FUNC_PEEK, '0, '0);
    send_word(FUNC_READ, '0, '0);
    send_word(FUNC_PUSH, '0, '1);
    send_word(FUNC_PUSH, '1, '0);
    send_word(FUNC_PEEK, '0, '0);
    send_word(FUNC_READ, '0, 6'd1);
    send_word(FUNC_READ, '1, 6'd2);
    send_word(FUNC_READ, '0, '1);
    send_word(FUNC_POP,  '0, '0);
    send_word(FUNC_POP,  '0, '0);
    send_word(FUNC_POP,  '0, '0);
  endtask

  task automatic test_capacity_lowered();
    send_word(FUNC_PUSH, 32'h1111_0001, '0);
    send_word(FUNC_PUSH, 32'h2222_0002, '0);
    send_word(FUNC_PUSH, 32'h3333_0003, '0);
    write_capacity(7'd2);
    send_word(FUNC_PUSH, 32'h4444_0004, '0);
    send_word(FUNC_READ, '0, '0);
    send_word(FUNC_POP,  '0, '0);
    send_word(FUNC_POP,  '0, '0);
    send_word(FUNC_PUSH, 32'h5555_0005, '0);
  endtask

  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_word(FUNC_PUSH, 32'hA5A5_5A5A, '0);
    send_word(FUNC_PUSH, 32'h5A5A_A5A5, '0);
  endtask

  task automatic test_fill_and_evict();
    write_capacity(7'd127);
    send_random_ops(140, 75);
    write_capacity(CAP_RESET);
    send_random_ops(100, 45);
  endtask

  task automatic test_small_capacities();
    write_capacity(7'd1);
    send_random_ops(40, 50);
    write_capacity(CAP_W'($urandom_range(2, 20)));
    send_random_ops(100, 55);
    write_capacity(7'd5);
    send_random_ops(60, 50);
  endtask

  task automatic test_no_idle();
    write_capacity(CAP_W'($urandom_range(8, 64)));
    burst_mode = 1'b1;
    send_random_ops(60, 55);
    drain_results();
    burst_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_results();
    rx_hold_cycles = HOLD_LEN;
    burst_mode = 1'b1;
    send_random_ops(30, 60);
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_PUSH;
    in_if.item      <= '0;
    in_if.index     <= '0;
    out_if.ready    <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.capacity <= CAP_RESET;
    for (int i = 0; i < HIST_DEPTH; i++) hist_ring[i] = '0;
    hist_oldest    = '0;
    hist_count     = 0;
    hist_cap       = CAP_RESET;
    err_cnt        = 0;
    words_sent     = 0;
    words_checked  = 0;
    push_cnt       = 0;
    evict_cnt      = 0;
    err_result_cnt = 0;
    burst_mode     = 1'b0;
    rx_hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_edges();
    test_capacity_lowered();
    test_capacity_zero();
    test_fill_and_evict();
    test_small_capacities();
    test_no_idle();
    test_backpressure();
    drain_results();

    $display("Ran %0d stack ops, %0d results checked: %0d pushes, %0d evictions, %0d errors",
             words_sent, words_checked, push_cnt, evict_cnt, err_result_cnt);
    $display("Capacities 0, 1, 2, 5, 64, 127 and random, with idling and a long output stall");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ bounded_undo_stack.f @@
sv/bus_pkg.sv
sv/bus_in_if.sv
sv/bus_out_if.sv
sv/bus_cfg_if.sv
sv/bus_ring_ram.sv
sv/bounded_undo_stack.sv
tb/sv/tb_bounded_undo_stack.sv
